// File: hw/rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, constants and types for the space vector pwm duty pipeline.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    // port widths
    localparam int VOLT_W    = 16;
    localparam int DUTY_W    = 16;
    localparam int CFG_W     = DUTY_W;
    localparam int CFG_IDX_W = 1;
    localparam int SEC_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 1'b1;

    // clamp defaults, 0.01 and 0.99 in q0.16
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST = DUTY_W'(655);
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST = DUTY_W'(64880);

    // sector codes from the three sign tests
    localparam logic [SEC_W-1:0] SEC_ZERO = 3'd0;
    localparam logic [SEC_W-1:0] SEC_1    = 3'd1;
    localparam logic [SEC_W-1:0] SEC_2    = 3'd2;
    localparam logic [SEC_W-1:0] SEC_3    = 3'd3;
    localparam logic [SEC_W-1:0] SEC_4    = 3'd4;
    localparam logic [SEC_W-1:0] SEC_5    = 3'd5;
    localparam logic [SEC_W-1:0] SEC_6    = 3'd6;
    localparam logic [SEC_W-1:0] SEC_BAD  = 3'd7;

    // sqrt(3) in q2.29
    localparam int                 SQ3_FRAC = 29;
    localparam logic signed [30:0] SQ3_Q29  = 31'sd929887697;

    // internal widths
    localparam int PROD_W   = VOLT_W + 31;   // voltage times sqrt3
    localparam int A3_W     = VOLT_W + 2;    // three times alpha
    localparam int NUM_W    = VOLT_W + 32;   // x, y, z before rounding
    localparam int SH_X     = VOLT_W - 2;
    localparam int SH_YZ    = VOLT_W - 1;
    localparam int PER_BITS = 30;            // one pwm period is 2^30
    localparam int T_W      = 33;            // x, y, z, m, s (signed)
    localparam int MAG_W    = 32;            // |m|, |s| and quotients
    localparam int SUM_W    = T_W + 1;
    localparam int DEN_W    = 33;            // divisor when scaling
    localparam int C_W      = 36;            // switching times times four
    localparam int D_W      = C_W + 2;       // duty at scale 2^32
    localparam int DUTY_SH  = 32 - DUTY_W;
    localparam int Q_W      = D_W - DUTY_SH; // rounded duty before clamp

    // values that travel with a beat through the divider
    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic             scale;
        logic             neg_m;
        logic             neg_s;
        logic [MAG_W-1:0] mag_m;
        logic [MAG_W-1:0] mag_s;
    } svpwm_side_t;

endpackage

// File: hw/rtl/svpwm_div.sv
// ----------------------------------------------------------------------------
// svpwm_div
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share one divisor: computes |m|*2^30/den and |s|*2^30/den, truncated.
// ----------------------------------------------------------------------------
module svpwm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  svpwm_pkg::svpwm_side_t    in_side,
    input  logic [svpwm_pkg::DEN_W-1:0] in_den,
    output logic                      out_valid,
    output svpwm_pkg::svpwm_side_t    out_side,
    output logic [svpwm_pkg::MAG_W-1:0] quo_a,
    output logic [svpwm_pkg::MAG_W-1:0] quo_b
);
    import svpwm_pkg::*;

    localparam int NSTG = MAG_W;

    // stage registers, index 0 holds the loaded beat
    logic              vld_reg   [0:NSTG];
    svpwm_side_t       side_reg  [0:NSTG];
    logic [DEN_W-1:0]  den_reg   [0:NSTG];
    logic [DEN_W-1:0]  rem_a_reg [0:NSTG];
    logic [DEN_W-1:0]  rem_b_reg [0:NSTG];
    logic [MAG_W-1:0]  nq_a_reg  [0:NSTG];
    logic [MAG_W-1:0]  nq_b_reg  [0:NSTG];

    logic [DEN_W-1:0]  rem_a_next [0:NSTG-1];
    logic [DEN_W-1:0]  rem_b_next [0:NSTG-1];
    logic [MAG_W-1:0]  nq_a_next  [0:NSTG-1];
    logic [MAG_W-1:0]  nq_b_next  [0:NSTG-1];

    logic [DEN_W:0]    sh_a   [0:NSTG-1];
    logic [DEN_W:0]    sh_b   [0:NSTG-1];
    logic [DEN_W+1:0]  diff_a [0:NSTG-1];
    logic [DEN_W+1:0]  diff_b [0:NSTG-1];

    // one trial subtract per stage and lane; dividend bits shift out of the
    // top of nq while quotient bits shift in at the bottom
    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            sh_a[k]   = {rem_a_reg[k], nq_a_reg[k][MAG_W-1]};
            sh_b[k]   = {rem_b_reg[k], nq_b_reg[k][MAG_W-1]};
            diff_a[k] = {1'b0, sh_a[k]} - {2'b00, den_reg[k]};
            diff_b[k] = {1'b0, sh_b[k]} - {2'b00, den_reg[k]};
            rem_a_next[k] = diff_a[k][DEN_W+1] ? sh_a[k][DEN_W-1:0] : diff_a[k][DEN_W-1:0];
            rem_b_next[k] = diff_b[k][DEN_W+1] ? sh_b[k][DEN_W-1:0] : diff_b[k][DEN_W-1:0];
            nq_a_next[k]  = {nq_a_reg[k][MAG_W-2:0], ~diff_a[k][DEN_W+1]};
            nq_b_next[k]  = {nq_b_reg[k][MAG_W-2:0], ~diff_b[k][DEN_W+1]};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < NSTG; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    // payload; the dividend is |x| * 2^30, its high part seeds the remainder
    always_ff @(posedge clk)
    begin
        side_reg[0]  <= in_side;
        den_reg[0]   <= in_den;
        rem_a_reg[0] <= DEN_W'(in_side.mag_m >> (MAG_W - PER_BITS));
        rem_b_reg[0] <= DEN_W'(in_side.mag_s >> (MAG_W - PER_BITS));
        nq_a_reg[0]  <= MAG_W'(in_side.mag_m << PER_BITS);
        nq_b_reg[0]  <= MAG_W'(in_side.mag_s << PER_BITS);
        for (int k = 0; k < NSTG; k++)
        begin
            side_reg[k+1]  <= side_reg[k];
            den_reg[k+1]   <= den_reg[k];
            rem_a_reg[k+1] <= rem_a_next[k];
            rem_b_reg[k+1] <= rem_b_next[k];
            nq_a_reg[k+1]  <= nq_a_next[k];
            nq_b_reg[k+1]  <= nq_b_next[k];
        end
    end

    assign out_valid = vld_reg[NSTG];
    assign out_side  = side_reg[NSTG];
    assign quo_a     = nq_a_reg[NSTG];
    assign quo_b     = nq_b_reg[NSTG];

    // a scaled beat keeps its remainders below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG] && side_reg[NSTG].scale |->
            (rem_a_reg[NSTG] < den_reg[NSTG]) && (rem_b_reg[NSTG] < den_reg[NSTG]))
        else $error("divider remainder not below divisor");

    // the divisor exceeds one period, so scaling never grows a time
    a_quo_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG] && side_reg[NSTG].scale |-> nq_a_reg[NSTG] <= side_reg[NSTG].mag_m)
        else $error("scaled m grew");

    a_quo_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG] && side_reg[NSTG].scale |-> nq_b_reg[NSTG] <= side_reg[NSTG].mag_s)
        else $error("scaled s grew");

endmodule

// File: hw/rtl/space_vector_pwm_duty.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Seven segment space vector pwm: alpha-beta voltage in, sector code and
// three clamped phase duties out.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; busy stays low, start may be held high.
// Depth is set by the overmodulation divider, a load stage and one quotient
// bit per stage over 32 stages, with four stages ahead of it and five after it.
// Reset clears every valid bit and loads the clamps with 0.01 and 0.99.
// Results are strobed by done for one cycle; the receiver cannot stall.
module space_vector_pwm_duty (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [svpwm_pkg::VOLT_W-1:0] v_alpha,
    input  logic signed [svpwm_pkg::VOLT_W-1:0] v_beta,
    output logic                                done,
    output logic [svpwm_pkg::DUTY_W-1:0]        duty_a,
    output logic [svpwm_pkg::DUTY_W-1:0]        duty_b,
    output logic [svpwm_pkg::DUTY_W-1:0]        duty_c,
    output logic [svpwm_pkg::SEC_W-1:0]         sector_code,
    input  logic                                cfg_wr_en,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svpwm_pkg::CFG_W-1:0]         cfg_data
);
    import svpwm_pkg::*;

    localparam logic signed [NUM_W-1:0] HALF_X   = NUM_W'(1) <<< (SH_X - 1);
    localparam logic signed [NUM_W-1:0] HALF_YZ  = NUM_W'(1) <<< (SH_YZ - 1);
    localparam logic signed [SUM_W-1:0] PER_SUM  = SUM_W'(1) <<< PER_BITS;
    localparam logic signed [C_W-1:0]   PER_C    = C_W'(1) <<< PER_BITS;
    localparam logic signed [D_W-1:0]   DUTY_ONE = D_W'(1) <<< 31;
    localparam logic signed [D_W-1:0]   HALF_D   = D_W'(1) <<< (DUTY_SH - 1);

    // clamp registers
    logic [DUTY_W-1:0] duty_min_reg, duty_max_reg;

    // stage 1: sqrt3 products
    logic                     p1_v_reg;
    logic signed [PROD_W-1:0] p1_pa_reg, p1_pb_reg, p1_pa_next, p1_pb_next;
    logic signed [A3_W-1:0]   p1_a3_reg, p1_a3_next;
    logic signed [VOLT_W-1:0] p1_b_reg;

    // stage 2: sector and unrounded x, y, z
    logic                     p2_v_reg;
    logic [SEC_W-1:0]         p2_sec_reg, p2_sec_next;
    logic signed [NUM_W-1:0]  p2_nx_reg, p2_ny_reg, p2_nz_reg;
    logic signed [NUM_W-1:0]  p2_nx_next, p2_ny_next, p2_nz_next;
    logic signed [NUM_W-1:0]  a15, b_sc, pa_w, t_ab, t_nab;

    // stage 3: rounded x, y, z
    logic                     p3_v_reg;
    logic [SEC_W-1:0]         p3_sec_reg;
    logic signed [T_W-1:0]    p3_x_reg, p3_y_reg, p3_z_reg;
    logic signed [T_W-1:0]    p3_x_next, p3_y_next, p3_z_next;
    logic signed [NUM_W-1:0]  rx, ry, rz;

    // stage 4: active vector times
    logic                     p4_v_reg;
    logic [SEC_W-1:0]         p4_sec_reg;
    logic signed [T_W-1:0]    p4_m_reg, p4_s_reg, p4_m_next, p4_s_next;

    // divider setup and output
    logic signed [SUM_W-1:0]  ms_sum;
    logic signed [T_W-1:0]    neg_m4, neg_s4;
    svpwm_side_t              div_in_side, div_out_side;
    logic [DEN_W-1:0]         div_in_den;
    logic                     div_out_v;
    logic [MAG_W-1:0]         quo_m, quo_s;

    // stage 6: scaled times
    logic                     p6_v_reg;
    logic [SEC_W-1:0]         p6_sec_reg;
    logic                     p6_scale_reg;
    logic signed [T_W-1:0]    p6_m_reg, p6_s_reg, p6_m_next, p6_s_next;
    logic signed [T_W-1:0]    m_abs, s_abs;

    // stage 7: switching times
    logic                     p7_v_reg;
    logic [SEC_W-1:0]         p7_sec_reg;
    logic signed [C_W-1:0]    p7_ta_reg, p7_tb_reg, p7_tc_reg;

    // stage 8: permuted compare times as duty numerators
    logic                     p8_v_reg;
    logic [SEC_W-1:0]         p8_sec_reg;
    logic signed [D_W-1:0]    p8_d1_reg, p8_d2_reg, p8_d3_reg;
    logic signed [D_W-1:0]    p8_d1_next, p8_d2_next, p8_d3_next;
    logic signed [C_W-1:0]    c1, c2, c3;

    // stage 9: rounded duties
    logic                     p9_v_reg;
    logic [SEC_W-1:0]         p9_sec_reg;
    logic signed [Q_W-1:0]    p9_q1_reg, p9_q2_reg, p9_q3_reg;
    logic signed [D_W-1:0]    rd1, rd2, rd3;

    // output registers
    logic                     done_reg;
    logic [DUTY_W-1:0]        duty_a_reg, duty_b_reg, duty_c_reg;
    logic [SEC_W-1:0]         sector_code_reg;

    function automatic logic [DUTY_W-1:0] duty_clamp(
        input logic signed [Q_W-1:0] q,
        input logic [DUTY_W-1:0]     lo,
        input logic [DUTY_W-1:0]     hi
    );
        logic signed [Q_W-1:0] lo_s;
        logic signed [Q_W-1:0] hi_s;
        lo_s = Q_W'(lo);
        hi_s = Q_W'(hi);
        if (q <= lo_s)
            return lo;
        else if (q < hi_s)
            return q[DUTY_W-1:0];
        else
            return hi;
    endfunction

    // full pipeline, a beat may enter every cycle
    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_min_reg <= DUTY_MIN_RST;
            duty_max_reg <= DUTY_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DUTY_MIN: duty_min_reg <= cfg_data[DUTY_W-1:0];
                REG_DUTY_MAX: duty_max_reg <= cfg_data[DUTY_W-1:0];
            endcase
        end
    end

    // stage 1 logic: constant multiplies and three alpha
    always_comb
    begin
        p1_pa_next = PROD_W'(v_alpha) * PROD_W'(SQ3_Q29);
        p1_pb_next = PROD_W'(v_beta) * PROD_W'(SQ3_Q29);
        p1_a3_next = A3_W'(v_alpha) + (A3_W'(v_alpha) <<< 1);
    end

    // stage 2 logic: sign tests and numerators of x, y, z
    always_comb
    begin
        pa_w       = NUM_W'(p1_pa_reg);
        b_sc       = NUM_W'(p1_b_reg) <<< SQ3_FRAC;
        a15        = NUM_W'(p1_a3_reg) <<< SQ3_FRAC;
        t_ab       = pa_w - b_sc;
        t_nab      = -pa_w - b_sc;
        p2_sec_next[0] = !p1_b_reg[VOLT_W-1] && (p1_b_reg != '0);
        p2_sec_next[1] = !t_ab[NUM_W-1] && (t_ab != '0);
        p2_sec_next[2] = !t_nab[NUM_W-1] && (t_nab != '0);
        p2_nx_next = NUM_W'(p1_pb_reg);
        p2_ny_next = NUM_W'(p1_pb_reg) + a15;
        p2_nz_next = NUM_W'(p1_pb_reg) - a15;
    end

    // stage 3 logic: round half away from zero
    always_comb
    begin
        rx = p2_nx_reg + (p2_nx_reg[NUM_W-1] ? HALF_X - NUM_W'(1) : HALF_X);
        ry = p2_ny_reg + (p2_ny_reg[NUM_W-1] ? HALF_YZ - NUM_W'(1) : HALF_YZ);
        rz = p2_nz_reg + (p2_nz_reg[NUM_W-1] ? HALF_YZ - NUM_W'(1) : HALF_YZ);
        p3_x_next = T_W'(rx >>> SH_X);
        p3_y_next = T_W'(ry >>> SH_YZ);
        p3_z_next = T_W'(rz >>> SH_YZ);
    end

    // stage 4 logic: pick the two active vector times
    always_comb
    begin
        unique case (p3_sec_reg)
            SEC_1:
            begin
                p4_m_next = p3_z_reg;
                p4_s_next = p3_y_reg;
            end
            SEC_2:
            begin
                p4_m_next = p3_y_reg;
                p4_s_next = -p3_x_reg;
            end
            SEC_3:
            begin
                p4_m_next = -p3_z_reg;
                p4_s_next = p3_x_reg;
            end
            SEC_4:
            begin
                p4_m_next = -p3_x_reg;
                p4_s_next = p3_z_reg;
            end
            SEC_5:
            begin
                p4_m_next = p3_x_reg;
                p4_s_next = -p3_y_reg;
            end
            default:
            begin
                p4_m_next = -p3_y_reg;
                p4_s_next = -p3_z_reg;
            end
        endcase
    end

    // divider setup: overmodulation test and magnitudes
    always_comb
    begin
        ms_sum = SUM_W'(p4_m_reg) + SUM_W'(p4_s_reg);
        neg_m4 = -p4_m_reg;
        neg_s4 = -p4_s_reg;
        div_in_side.sector = p4_sec_reg;
        div_in_side.scale  = ms_sum > PER_SUM;
        div_in_side.neg_m  = p4_m_reg[T_W-1];
        div_in_side.neg_s  = p4_s_reg[T_W-1];
        div_in_side.mag_m  = p4_m_reg[T_W-1] ? neg_m4[MAG_W-1:0] : p4_m_reg[MAG_W-1:0];
        div_in_side.mag_s  = p4_s_reg[T_W-1] ? neg_s4[MAG_W-1:0] : p4_s_reg[MAG_W-1:0];
        div_in_den         = ms_sum[DEN_W-1:0];
    end

    svpwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p4_v_reg),
        .in_side   (div_in_side),
        .in_den    (div_in_den),
        .out_valid (div_out_v),
        .out_side  (div_out_side),
        .quo_a     (quo_m),
        .quo_b     (quo_s)
    );

    // stage 6 logic: take the quotient when scaling, restore signs
    always_comb
    begin
        m_abs = T_W'(div_out_side.scale ? quo_m : div_out_side.mag_m);
        s_abs = T_W'(div_out_side.scale ? quo_s : div_out_side.mag_s);
        p6_m_next = div_out_side.neg_m ? -m_abs : m_abs;
        p6_s_next = div_out_side.neg_s ? -s_abs : s_abs;
    end

    // stage 8 logic: per sector permutation, then 2*(1 - tcmp) at 2^32
    always_comb
    begin
        unique case (p7_sec_reg)
            SEC_1:
            begin
                c1 = p7_tb_reg;
                c2 = p7_ta_reg;
                c3 = p7_tc_reg;
            end
            SEC_2:
            begin
                c1 = p7_ta_reg;
                c2 = p7_tc_reg;
                c3 = p7_tb_reg;
            end
            SEC_3:
            begin
                c1 = p7_ta_reg;
                c2 = p7_tb_reg;
                c3 = p7_tc_reg;
            end
            SEC_4:
            begin
                c1 = p7_tc_reg;
                c2 = p7_tb_reg;
                c3 = p7_ta_reg;
            end
            SEC_5:
            begin
                c1 = p7_tc_reg;
                c2 = p7_ta_reg;
                c3 = p7_tb_reg;
            end
            SEC_6:
            begin
                c1 = p7_tb_reg;
                c2 = p7_tc_reg;
                c3 = p7_ta_reg;
            end
            default:
            begin
                // zero vector: every duty at full scale
                c1 = '0;
                c2 = '0;
                c3 = '0;
            end
        endcase
        p8_d1_next = (DUTY_ONE - D_W'(c1)) <<< 1;
        p8_d2_next = (DUTY_ONE - D_W'(c2)) <<< 1;
        p8_d3_next = (DUTY_ONE - D_W'(c3)) <<< 1;
    end

    // stage 9 logic: round duties half away from zero
    always_comb
    begin
        rd1 = p8_d1_reg + (p8_d1_reg[D_W-1] ? HALF_D - D_W'(1) : HALF_D);
        rd2 = p8_d2_reg + (p8_d2_reg[D_W-1] ? HALF_D - D_W'(1) : HALF_D);
        rd3 = p8_d3_reg + (p8_d3_reg[D_W-1] ? HALF_D - D_W'(1) : HALF_D);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
            p7_v_reg <= 1'b0;
            p8_v_reg <= 1'b0;
            p9_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= start && !busy;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p6_v_reg <= div_out_v;
            p7_v_reg <= p6_v_reg;
            p8_v_reg <= p7_v_reg;
            p9_v_reg <= p8_v_reg;
            done_reg <= p9_v_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p1_pa_reg  <= p1_pa_next;
        p1_pb_reg  <= p1_pb_next;
        p1_a3_reg  <= p1_a3_next;
        p1_b_reg   <= v_beta;

        p2_sec_reg <= p2_sec_next;
        p2_nx_reg  <= p2_nx_next;
        p2_ny_reg  <= p2_ny_next;
        p2_nz_reg  <= p2_nz_next;

        p3_sec_reg <= p2_sec_reg;
        p3_x_reg   <= p3_x_next;
        p3_y_reg   <= p3_y_next;
        p3_z_reg   <= p3_z_next;

        p4_sec_reg <= p3_sec_reg;
        p4_m_reg   <= p4_m_next;
        p4_s_reg   <= p4_s_next;

        p6_sec_reg   <= div_out_side.sector;
        p6_scale_reg <= div_out_side.scale;
        p6_m_reg     <= p6_m_next;
        p6_s_reg     <= p6_s_next;

        // ta = 1 - m - s, tb = ta + 2m, tc = tb + 2s
        p7_sec_reg <= p6_sec_reg;
        p7_ta_reg  <= PER_C - C_W'(p6_m_reg) - C_W'(p6_s_reg);
        p7_tb_reg  <= PER_C + C_W'(p6_m_reg) - C_W'(p6_s_reg);
        p7_tc_reg  <= PER_C + C_W'(p6_m_reg) + C_W'(p6_s_reg);

        p8_sec_reg <= p7_sec_reg;
        p8_d1_reg  <= p8_d1_next;
        p8_d2_reg  <= p8_d2_next;
        p8_d3_reg  <= p8_d3_next;

        p9_sec_reg <= p8_sec_reg;
        p9_q1_reg  <= Q_W'(rd1 >>> DUTY_SH);
        p9_q2_reg  <= Q_W'(rd2 >>> DUTY_SH);
        p9_q3_reg  <= Q_W'(rd3 >>> DUTY_SH);

        // clamp into the output beat
        sector_code_reg <= p9_sec_reg;
        duty_a_reg      <= duty_clamp(p9_q1_reg, duty_min_reg, duty_max_reg);
        duty_b_reg      <= duty_clamp(p9_q2_reg, duty_min_reg, duty_max_reg);
        duty_c_reg      <= duty_clamp(p9_q3_reg, duty_min_reg, duty_max_reg);
    end

    assign done        = done_reg;
    assign duty_a      = duty_a_reg;
    assign duty_b      = duty_b_reg;
    assign duty_c      = duty_c_reg;
    assign sector_code = sector_code_reg;

    // the three sign tests can never all pass
    a_no_bad_sector: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> sector_code != SEC_BAD)
        else $error("impossible sector code delivered");

    // a zero vector puts every phase at the upper clamp
    a_zero_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && (sector_code == SEC_ZERO) |->
            (duty_a == $past(duty_max_reg)) && (duty_b == $past(duty_max_reg)) &&
            (duty_c == $past(duty_max_reg)))
        else $error("zero vector duty not at upper clamp");

    // after overmodulation scaling the active times fit in one period
    a_scaled_fits: assert property (@(posedge clk) disable iff (!rst_n)
        p6_v_reg && p6_scale_reg |-> (SUM_W'(p6_m_reg) + SUM_W'(p6_s_reg)) <= PER_SUM)
        else $error("scaled active times exceed the period");

endmodule

// File: tb/sv/svpwm_duty_checker.sv
// ----------------------------------------------------------------------------
// svpwm_duty_checker
// Watches the sample and result channels of the svpwm duty block, predicts
// the sector code and the three clamped duties of every accepted sample, and
// compares each result beat with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module svpwm_duty_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [svpwm_pkg::VOLT_W-1:0] v_alpha,
    input  logic signed [svpwm_pkg::VOLT_W-1:0] v_beta,
    input  logic                                done,
    input  logic [svpwm_pkg::DUTY_W-1:0]        duty_a,
    input  logic [svpwm_pkg::DUTY_W-1:0]        duty_b,
    input  logic [svpwm_pkg::DUTY_W-1:0]        duty_c,
    input  logic [svpwm_pkg::SEC_W-1:0]         sector_code,
    input  logic                                cfg_wr_en,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svpwm_pkg::CFG_W-1:0]         cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PERIOD = longint'(1) <<< svpwm_pkg::PER_BITS;

    // one predicted result, with the sample that caused it
    typedef struct packed {
        logic [svpwm_pkg::VOLT_W-1:0] va;
        logic [svpwm_pkg::VOLT_W-1:0] vb;
        logic [svpwm_pkg::DUTY_W-1:0] da;
        logic [svpwm_pkg::DUTY_W-1:0] db;
        logic [svpwm_pkg::DUTY_W-1:0] dc;
        logic [svpwm_pkg::SEC_W-1:0]  sec;
    } duty_set_t;

    logic [svpwm_pkg::DUTY_W-1:0] duty_lo;
    logic [svpwm_pkg::DUTY_W-1:0] duty_hi;
    duty_set_t                    duty_q [$];
    int                           n_reported;

    initial
    begin
        fail_count = 0;
        n_reported = 0;
        pending    = 0;
    end

    // rounding right shift, ties away from zero
    function automatic longint round_away(longint x, int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (x >= 0)
            return (x + half) >>> n;
        return -((-x + half) >>> n);
    endfunction

    // duty = 1 - 2*tcmp at scale 2^32, rounded to q0.16, then clamped
    function automatic logic [svpwm_pkg::DUTY_W-1:0] clamp_duty(longint tcmp4);
        longint q;
        q = round_away(((longint'(1) <<< 31) - tcmp4) * 2, svpwm_pkg::DUTY_SH);
        if (q <= longint'(duty_lo))
            return duty_lo;
        if (q < longint'(duty_hi))
            return q[svpwm_pkg::DUTY_W-1:0];
        return duty_hi;
    endfunction

    // sector, active vector times, overmodulation limit and compare times
    function automatic duty_set_t predict_duties(logic signed [svpwm_pkg::VOLT_W-1:0] va,
                                                 logic signed [svpwm_pkg::VOLT_W-1:0] vb);
        longint    a, b, sq3, a_sq3, b_sq3, b_sc, a_3;
        longint    x, y, z, m, s, sum, ta4, tb4, tc4, c1, c2, c3;
        duty_set_t r;
        a     = va;
        b     = vb;
        sq3   = svpwm_pkg::SQ3_Q29;
        a_sq3 = a * sq3;
        b_sq3 = b * sq3;
        b_sc  = b * (longint'(1) <<< svpwm_pkg::SQ3_FRAC);
        a_3   = a * 3 * (longint'(1) <<< svpwm_pkg::SQ3_FRAC);

        // three sign tests, one bit each
        r.sec = {(-a_sq3 - b_sc > 0), (a_sq3 - b_sc > 0), (b > 0)};

        x = round_away(b_sq3, svpwm_pkg::SH_X);
        y = round_away(a_3 + b_sq3, svpwm_pkg::SH_YZ);
        z = round_away(-a_3 + b_sq3, svpwm_pkg::SH_YZ);

        case (r.sec)
            svpwm_pkg::SEC_1:
            begin
                m = z;
                s = y;
            end
            svpwm_pkg::SEC_2:
            begin
                m = y;
                s = -x;
            end
            svpwm_pkg::SEC_3:
            begin
                m = -z;
                s = x;
            end
            svpwm_pkg::SEC_4:
            begin
                m = -x;
                s = z;
            end
            svpwm_pkg::SEC_5:
            begin
                m = x;
                s = -y;
            end
            default:
            begin
                m = -y;
                s = -z;
            end
        endcase

        // scale both times back onto the hexagon when they overrun the period
        if (m + s > PERIOD)
        begin
            sum = m + s;
            m   = (m * PERIOD) / sum;
            s   = (s * PERIOD) / sum;
        end

        ta4 = PERIOD - (m + s);
        tb4 = ta4 + 2 * m;
        tc4 = tb4 + 2 * s;

        // per-sector phase permutation, zero vector leaves all times at zero
        c1 = 0;
        c2 = 0;
        c3 = 0;
        case (r.sec)
            svpwm_pkg::SEC_1:
            begin
                c1 = tb4; c2 = ta4; c3 = tc4;
            end
            svpwm_pkg::SEC_2:
            begin
                c1 = ta4; c2 = tc4; c3 = tb4;
            end
            svpwm_pkg::SEC_3:
            begin
                c1 = ta4; c2 = tb4; c3 = tc4;
            end
            svpwm_pkg::SEC_4:
            begin
                c1 = tc4; c2 = tb4; c3 = ta4;
            end
            svpwm_pkg::SEC_5:
            begin
                c1 = tc4; c2 = ta4; c3 = tb4;
            end
            svpwm_pkg::SEC_6:
            begin
                c1 = tb4; c2 = tc4; c3 = ta4;
            end
            default: ;
        endcase

        r.va = va;
        r.vb = vb;
        r.da = clamp_duty(c1);
        r.db = clamp_duty(c2);
        r.dc = clamp_duty(c3);
        return r;
    endfunction

    // watch result, config and sample beats at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        duty_set_t want;
        if (!rst_n)
        begin
            duty_lo = svpwm_pkg::DUTY_MIN_RST;
            duty_hi = svpwm_pkg::DUTY_MAX_RST;
            duty_q.delete();
            pending = 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (done === 1'b1)
            begin
                if (duty_q.size() == 0)
                begin
                    fail_count++;
                    if (n_reported < 10)
                        $display("%0t: unexpected result beat: a %0d b %0d c %0d sector %0d",
                                 $realtime, duty_a, duty_b, duty_c, sector_code);
                    n_reported++;
                end
                else
                begin
                    want = duty_q.pop_front();
                    if (duty_a !== want.da || duty_b !== want.db || duty_c !== want.dc ||
                        sector_code !== want.sec)
                    begin
                        fail_count++;
                        if (n_reported < 10)
                        begin
                            $display("%0t: mismatch for alpha %0d beta %0d",
                                     $realtime, $signed(want.va), $signed(want.vb));
                            $display("    expected a %0d b %0d c %0d sector %0d",
                                     want.da, want.db, want.dc, want.sec);
                            $display("    got      a %0d b %0d c %0d sector %0d",
                                     duty_a, duty_b, duty_c, sector_code);
                        end
                        n_reported++;
                    end
                end
            end

            // clamp register writes
            if (cfg_wr_en === 1'b1)
            begin
                if (cfg_index == svpwm_pkg::REG_DUTY_MIN)
                    duty_lo = cfg_data[svpwm_pkg::DUTY_W-1:0];
                else if (cfg_index == svpwm_pkg::REG_DUTY_MAX)
                    duty_hi = cfg_data[svpwm_pkg::DUTY_W-1:0];
            end

            // accepted sample beat
            if (start === 1'b1 && busy === 1'b0)
                duty_q.push_back(predict_duties(v_alpha, v_beta));

            pending = duty_q.size();
        end
    end

endmodule

// File: tb/sv/tb_space_vector_pwm_duty.sv
// ----------------------------------------------------------------------------
// tb_space_vector_pwm_duty
// Drives alpha-beta samples into the svpwm duty block under several clamp
// settings: a directed set of axes, extremes and one point per sector, then
// random samples with random input gaps. A checker predicts every result.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_duty;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 42;
    localparam int N_DIR   = 21;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic signed [svpwm_pkg::VOLT_W-1:0] v_alpha;
    logic signed [svpwm_pkg::VOLT_W-1:0] v_beta;
    logic                                done;
    logic [svpwm_pkg::DUTY_W-1:0]        duty_a;
    logic [svpwm_pkg::DUTY_W-1:0]        duty_b;
    logic [svpwm_pkg::DUTY_W-1:0]        duty_c;
    logic [svpwm_pkg::SEC_W-1:0]         sector_code;
    logic                                cfg_wr_en;
    logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [svpwm_pkg::CFG_W-1:0]         cfg_data;
    int                                  fail_count;
    int                                  pending;
    bit                                  calm;

    // axes, corners, one point per sector, a sector edge and overmodulation
    int dir_alpha [N_DIR] = '{0, 1, -1, 0, 0, 32767, -32768, 0, 0,
                              32767, -32768, 32767, -32768,
                              14189, 2845, -14189, -14189, -2845, 14189,
                              8192, 30000};
    int dir_beta  [N_DIR] = '{0, 0, 0, 1, -1, 0, 0, 32767, -32768,
                              32767, -32768, -32768, 32767,
                              8192, 16135, 8192, -8192, -16135, -8192,
                              14189, 10000};

    space_vector_pwm_duty dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .v_alpha     (v_alpha),
        .v_beta      (v_beta),
        .done        (done),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .sector_code (sector_code),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    svpwm_duty_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .v_alpha     (v_alpha),
        .v_beta      (v_beta),
        .done        (done),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .sector_code (sector_code),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    // one sample beat, with an occasional random gap ahead of it
    task automatic send_sample(input int a, input int b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap   = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        v_alpha <= svpwm_pkg::VOLT_W'(a);
        v_beta  <= svpwm_pkg::VOLT_W'(b);
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // both clamp registers, back to back
    task automatic write_clamps(input logic [svpwm_pkg::CFG_W-1:0] lo,
                                input logic [svpwm_pkg::CFG_W-1:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= svpwm_pkg::REG_DUTY_MIN;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= svpwm_pkg::REG_DUTY_MAX;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random sample: full range, inside the hexagon, tiny, axes, sector edges
    task automatic random_sample(output int a, output int b);
        int sel;
        int vals [5];
        vals = '{-32768, -1, 0, 1, 32767};
        sel  = $urandom_range(0, 9);
        if (sel <= 3)
        begin
            a = $signed(16'($urandom));
            b = $signed(16'($urandom));
        end
        else if (sel <= 6)
        begin
            a = int'($urandom_range(0, 36000)) - 18000;
            b = int'($urandom_range(0, 36000)) - 18000;
        end
        else if (sel == 7)
        begin
            a = int'($urandom_range(0, 8)) - 4;
            b = int'($urandom_range(0, 8)) - 4;
        end
        else if (sel == 8)
        begin
            a = vals[$urandom_range(0, 4)];
            b = vals[$urandom_range(0, 4)];
        end
        else
        begin
            a = $urandom_range(0, 18000);
            b = (a * 1732) / 1000 + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1))
                a = -a;
            if ($urandom_range(0, 1))
                b = -b;
        end
    endtask

    // random samples under one clamp setting
    task automatic run_random(input int count, input int calm_from);
        int a, b;
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= calm_from);
            random_sample(a, b);
            send_sample(a, b);
        end
    endtask

    task automatic run_phase(input logic [svpwm_pkg::CFG_W-1:0] lo,
                             input logic [svpwm_pkg::CFG_W-1:0] hi,
                             input int count, input int calm_from);
        drain();
        write_clamps(lo, hi);
        run_random(count, calm_from);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        v_alpha   = '0;
        v_beta    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = svpwm_pkg::REG_DUTY_MIN;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset clamps: directed points, then random
        for (int i = 0; i < N_DIR; i++)
            send_sample(dir_alpha[i], dir_beta[i]);
        run_random(40, 40);

        // full range, inverted, both clamps at each end, inverted mid-range, random, defaults
        run_phase(16'd0, 16'd65535, 70, 70);
        run_phase(16'd65535, 16'd0, 50, 50);
        run_phase(16'd0, 16'd0, 40, 40);
        run_phase(16'd65535, 16'd65535, 40, 40);
        run_phase(16'd40000, 16'd20000, 50, 50);
        run_phase(16'($urandom), 16'($urandom), 60, 60);
        run_phase(svpwm_pkg::DUTY_MIN_RST, svpwm_pkg::DUTY_MAX_RST, 100, 40);

        drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
